// ===== rtl/hllru_pkg.sv =====
// Package for the HyperLogLog register update unit.
// Holds the fixed field widths, operation codes and the group leading-zero helper.
// No dependencies.
package hllru_pkg;

  localparam int HASH_W      = 64;
  localparam int OP_W        = 1;
  localparam int REG_INDEX_W = 10;
  localparam int RANK_W      = 6;
  localparam int COUNT_W     = 11;
  localparam int GROUP_W     = 8;
  localparam int NUM_GROUPS  = HASH_W / GROUP_W;
  localparam int GROUP_LZ_W  = $clog2(GROUP_W);

  localparam logic [OP_W-1:0] OP_ADD     = 1'b0;
  localparam logic [OP_W-1:0] OP_READOUT = 1'b1;

  // Leading zeros of a non-zero byte, counted from its top bit.
  function automatic logic [GROUP_LZ_W-1:0] group_lz(input logic [GROUP_W-1:0] grp);
    logic [GROUP_LZ_W-1:0] lz;
    lz = '0;
    for (int b = 0; b < GROUP_W; b++) begin
      if (grp[b]) begin
        lz = GROUP_LZ_W'(GROUP_W - 1 - b);
      end
    end
    return lz;
  endfunction

endpackage

// ===== rtl/hllru_if.sv =====
// Channel interfaces for the HyperLogLog register update unit.
// Depends on hllru_pkg for the payload widths.
interface hllru_item_if;
  import hllru_pkg::*;
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [HASH_W-1:0] hash_value;
  modport source(output valid, op, hash_value, input ready);
  modport sink(input valid, op, hash_value, output ready);
endinterface

interface hllru_result_if;
  import hllru_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [REG_INDEX_W-1:0] reg_index;
  logic [RANK_W-1:0]      old_rank;
  logic [RANK_W-1:0]      new_rank;
  logic                   raised;
  logic [COUNT_W-1:0]     empty_registers;
  logic [RANK_W-1:0]      bin_rank;
  logic [COUNT_W-1:0]     bin_count;
  logic                   last;
  modport source(output valid, reg_index, old_rank, new_rank, raised, empty_registers,
                 bin_rank, bin_count, last, input ready);
  modport sink(input valid, reg_index, old_rank, new_rank, raised, empty_registers,
               bin_rank, bin_count, last, output ready);
endinterface

// ===== rtl/hllru_front.sv =====
// Front end: accepts items, splits the hash into register index and rank.
// Depends on hllru_pkg and hllru_if.
module hllru_front #(
  parameter int INDEX_BITS = 10
) (
  input  logic                             clk,
  input  logic                             rst,
  hllru_item_if.sink                       item,
  input  logic                             q_full,
  output logic                             push,
  output logic [hllru_pkg::OP_W-1:0]       push_op,
  output logic [INDEX_BITS-1:0]            push_idx,
  output logic [hllru_pkg::RANK_W-1:0]     push_rank
);
  import hllru_pkg::*;

  localparam int MAX_RANK = 65 - INDEX_BITS;

  logic                  fvalid;
  logic [OP_W-1:0]       fop;
  logic [INDEX_BITS-1:0] fidx;
  logic [NUM_GROUPS-1:0] fnz;
  logic [GROUP_LZ_W-1:0] flz [NUM_GROUPS];

  logic [HASH_W-1:0]     rest;
  logic [NUM_GROUPS-1:0] nz;
  logic [GROUP_LZ_W-1:0] lz [NUM_GROUPS];
  logic                  accept;

  assign item.ready = !rst && (!fvalid || !q_full);
  assign accept     = item.valid && item.ready;
  assign push       = fvalid && !q_full;

  // The bits below the index are moved to the top; the zero fill below them
  // never holds a one, so an all-zero remainder leaves every group empty.
  always_comb begin
    rest = HASH_W'(item.hash_value << INDEX_BITS);
    for (int g = 0; g < NUM_GROUPS; g++) begin
      nz[g] = |rest[HASH_W-1-GROUP_W*g -: GROUP_W];
      lz[g] = group_lz(rest[HASH_W-1-GROUP_W*g -: GROUP_W]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fvalid <= 1'b0;
    end else if (accept) begin
      fvalid <= 1'b1;
    end else if (push) begin
      fvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fop  <= item.op;
      fidx <= item.hash_value[HASH_W-1 -: INDEX_BITS];
      fnz  <= nz;
      for (int g = 0; g < NUM_GROUPS; g++) begin
        flz[g] <= lz[g];
      end
    end
  end

  // The first non-empty group, counted from the top, sets the rank.
  always_comb begin
    push_rank = RANK_W'(MAX_RANK);
    for (int g = NUM_GROUPS - 1; g >= 0; g--) begin
      if (fnz[g]) begin
        push_rank = RANK_W'(GROUP_W * g + 1) + RANK_W'(flz[g]);
      end
    end
  end

  assign push_op  = fop;
  assign push_idx = fidx;

endmodule

// ===== rtl/hllru_queue.sv =====
// Small register queue between the front end and the back end.
// Depends on nothing.
module hllru_queue #(
  parameter int DATA_W = 17,
  parameter int DEPTH  = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  input  logic              pop,
  output logic [DATA_W-1:0] head,
  output logic              full,
  output logic              empty
);
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] slots [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;

  assign full  = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

// ===== rtl/hllru_back.sv =====
// Back end: rank store and histogram memories, add and readout sequencing,
// and the result register. Depends on hllru_pkg and hllru_if.
module hllru_back #(
  parameter int INDEX_BITS = 10
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_empty,
  input  logic [hllru_pkg::OP_W-1:0]    q_op,
  input  logic [INDEX_BITS-1:0]         q_idx,
  input  logic [hllru_pkg::RANK_W-1:0]  q_rank,
  output logic                          pop,
  output logic                          clearing,
  hllru_result_if.source                result
);
  import hllru_pkg::*;

  localparam int NUM_REGS = 1 << INDEX_BITS;
  localparam int NUM_BINS = 66 - INDEX_BITS;
  localparam int HIST_AW  = $clog2(NUM_BINS);
  localparam int CNT_W    = INDEX_BITS + 1;

  localparam logic [2:0] ST_CLEAR   = 3'd0;
  localparam logic [2:0] ST_IDLE    = 3'd1;
  localparam logic [2:0] ST_ADD_RD  = 3'd2;
  localparam logic [2:0] ST_ADD_INC = 3'd3;
  localparam logic [2:0] ST_ADD_DEC = 3'd4;
  localparam logic [2:0] ST_ADD_OUT = 3'd5;
  localparam logic [2:0] ST_RO      = 3'd6;

  logic [RANK_W-1:0] rank_mem [NUM_REGS];
  logic [CNT_W-1:0]  hist_mem [NUM_BINS];

  logic [2:0]            state, state_next;
  logic [INDEX_BITS-1:0] clr_addr, clr_addr_next;
  logic [INDEX_BITS-1:0] cur_idx, cur_idx_next;
  logic [RANK_W-1:0]     cur_rank, cur_rank_next;
  logic [RANK_W-1:0]     old_r, old_r_next;
  logic [RANK_W-1:0]     new_r, new_r_next;
  logic                  raised_r, raised_r_next;
  logic [CNT_W-1:0]      empty, empty_next;
  logic [RANK_W-1:0]     ptr, ptr_next;

  logic                  rank_we;
  logic [INDEX_BITS-1:0] rank_waddr, rank_raddr;
  logic [RANK_W-1:0]     rank_wdata, rank_rdata;
  logic                  hist_we;
  logic [HIST_AW-1:0]    hist_waddr, hist_raddr;
  logic [CNT_W-1:0]      hist_wdata, hist_rdata;

  logic                  out_valid, out_load, slot_free;
  logic [REG_INDEX_W-1:0] ld_index;
  logic [RANK_W-1:0]     ld_old, ld_new, ld_bin_rank;
  logic                  ld_raised, ld_last;
  logic [COUNT_W-1:0]    ld_empty, ld_bin_count;
  logic                  bin_last;

  assign slot_free = !out_valid || result.ready;
  assign clearing  = (state == ST_CLEAR);
  assign bin_last  = (ptr == RANK_W'(NUM_BINS - 1));

  always_comb begin
    state_next    = state;
    clr_addr_next = clr_addr;
    cur_idx_next  = cur_idx;
    cur_rank_next = cur_rank;
    old_r_next    = old_r;
    new_r_next    = new_r;
    raised_r_next = raised_r;
    empty_next    = empty;
    ptr_next      = ptr;
    pop           = 1'b0;
    rank_we       = 1'b0;
    rank_waddr    = cur_idx;
    rank_wdata    = cur_rank;
    rank_raddr    = q_idx;
    hist_we       = 1'b0;
    hist_waddr    = HIST_AW'(new_r);
    hist_wdata    = hist_rdata + 1'b1;
    hist_raddr    = HIST_AW'(ptr);
    out_load      = 1'b0;
    ld_index      = REG_INDEX_W'(cur_idx);
    ld_old        = old_r;
    ld_new        = new_r;
    ld_raised     = raised_r;
    ld_empty      = COUNT_W'(empty);
    ld_bin_rank   = '0;
    ld_bin_count  = '0;
    ld_last       = 1'b1;
    case (state)
      ST_CLEAR: begin
        rank_we    = 1'b1;
        rank_waddr = clr_addr;
        rank_wdata = '0;
        if (clr_addr < INDEX_BITS'(NUM_BINS)) begin
          hist_we    = 1'b1;
          hist_waddr = HIST_AW'(clr_addr);
          hist_wdata = '0;
        end
        clr_addr_next = clr_addr + 1'b1;
        if (clr_addr == INDEX_BITS'(NUM_REGS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (!q_empty) begin
          pop           = 1'b1;
          cur_idx_next  = q_idx;
          cur_rank_next = q_rank;
          ptr_next      = '0;
          hist_raddr    = '0;
          state_next    = (q_op == OP_ADD) ? ST_ADD_RD : ST_RO;
        end
      end
      ST_ADD_RD: begin
        old_r_next = rank_rdata;
        if (cur_rank > rank_rdata) begin
          raised_r_next = 1'b1;
          new_r_next    = cur_rank;
          rank_we       = 1'b1;
          hist_raddr    = HIST_AW'(cur_rank);
          if (rank_rdata == '0) begin
            empty_next = empty - 1'b1;
          end
          state_next = ST_ADD_INC;
        end else begin
          raised_r_next = 1'b0;
          new_r_next    = rank_rdata;
          state_next    = ST_ADD_OUT;
        end
      end
      ST_ADD_INC: begin
        // Bin zero lives in the empty counter, so only a non-zero old rank
        // needs its bin decremented.
        hist_we    = 1'b1;
        hist_waddr = HIST_AW'(new_r);
        hist_wdata = hist_rdata + 1'b1;
        hist_raddr = HIST_AW'(old_r);
        state_next = (old_r != '0) ? ST_ADD_DEC : ST_ADD_OUT;
      end
      ST_ADD_DEC: begin
        hist_we    = 1'b1;
        hist_waddr = HIST_AW'(old_r);
        hist_wdata = hist_rdata - 1'b1;
        state_next = ST_ADD_OUT;
      end
      ST_ADD_OUT: begin
        if (slot_free) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_RO: begin
        ld_index     = '0;
        ld_old       = '0;
        ld_new       = '0;
        ld_raised    = 1'b0;
        ld_bin_rank  = ptr;
        ld_bin_count = (ptr == '0) ? COUNT_W'(empty) : COUNT_W'(hist_rdata);
        ld_last      = bin_last;
        // The read address stays on the current bin while the result waits.
        if (slot_free) begin
          out_load = 1'b1;
          if (bin_last) begin
            ptr_next   = '0;
            hist_raddr = '0;
            state_next = ST_IDLE;
          end else begin
            ptr_next   = ptr + 1'b1;
            hist_raddr = HIST_AW'(ptr + 1'b1);
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_addr  <= '0;
      empty     <= CNT_W'(NUM_REGS);
      ptr       <= '0;
      out_valid <= 1'b0;
    end else begin
      state    <= state_next;
      clr_addr <= clr_addr_next;
      empty    <= empty_next;
      ptr      <= ptr_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_idx  <= cur_idx_next;
    cur_rank <= cur_rank_next;
    old_r    <= old_r_next;
    new_r    <= new_r_next;
    raised_r <= raised_r_next;
  end

  always_ff @(posedge clk) begin
    if (rank_we) begin
      rank_mem[rank_waddr] <= rank_wdata;
    end
    rank_rdata <= rank_mem[rank_raddr];
  end

  always_ff @(posedge clk) begin
    if (hist_we) begin
      hist_mem[hist_waddr] <= hist_wdata;
    end
    hist_rdata <= hist_mem[hist_raddr];
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result.reg_index       <= ld_index;
      result.old_rank        <= ld_old;
      result.new_rank        <= ld_new;
      result.raised          <= ld_raised;
      result.empty_registers <= ld_empty;
      result.bin_rank        <= ld_bin_rank;
      result.bin_count       <= ld_bin_count;
      result.last            <= ld_last;
    end
  end

  assign result.valid = out_valid;

endmodule

// ===== rtl/hyperloglog_register_update_unit.sv =====
// HyperLogLog register update unit: top level.
// Depends on hllru_pkg, hllru_if, hllru_front, hllru_queue and hllru_back.

// After reset the unit clears its rank store and histogram memory and
// takes no item from its queue until that pass is done; up to five items may
// still be accepted into the front end and queue meanwhile. An add reads the
// old rank; if it raises the register, it writes the new rank, increments the
// new rank's bin and, unless the old rank was zero, decrements the old rank's
// bin, using the separate read and write ports of the rank store and of the
// histogram memory. A readout gives one result per bin, one per cycle while
// the sink keeps up. The front end classifies items at one per cycle unless
// its four-entry queue is full, so bursts are absorbed in that queue.
module hyperloglog_register_update_unit #(
  parameter int INDEX_BITS = 10
) (
  input  logic           clk,
  input  logic           rst,
  hllru_item_if.sink     item,
  hllru_result_if.source result
);
  import hllru_pkg::*;

  localparam int Q_DATA_W = OP_W + INDEX_BITS + RANK_W;
  localparam int NUM_BINS = 66 - INDEX_BITS;

  logic                  push, pop, q_full, q_empty, clearing;
  logic [OP_W-1:0]       push_op, q_op;
  logic [INDEX_BITS-1:0] push_idx, q_idx;
  logic [RANK_W-1:0]     push_rank, q_rank;
  logic [Q_DATA_W-1:0]   q_head;

  hllru_front #(.INDEX_BITS(INDEX_BITS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .q_full    (q_full),
    .push      (push),
    .push_op   (push_op),
    .push_idx  (push_idx),
    .push_rank (push_rank)
  );

  hllru_queue #(.DATA_W(Q_DATA_W), .DEPTH(4)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data ({push_op, push_idx, push_rank}),
    .pop       (pop),
    .head      (q_head),
    .full      (q_full),
    .empty     (q_empty)
  );

  assign {q_op, q_idx, q_rank} = q_head;

  hllru_back #(.INDEX_BITS(INDEX_BITS)) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .q_op     (q_op),
    .q_idx    (q_idx),
    .q_rank   (q_rank),
    .pop      (pop),
    .clearing (clearing),
    .result   (result)
  );

  a_no_result_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !result.valid)
    else $error("result presented during the clearing pass");

  a_queue_flags: assert property (@(posedge clk) disable iff (rst)
    !(q_full && q_empty) && !(pop && q_empty))
    else $error("queue flags inconsistent or pop from an empty queue");

  a_raise_orders_ranks: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.raised |-> result.new_rank > result.old_rank)
    else $error("raised result without a larger new rank");

  a_last_bin: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.bin_rank != '0 |->
      (result.last == (result.bin_rank == RANK_W'(NUM_BINS - 1))) && !result.raised)
    else $error("readout result with wrong last mark or add fields set");

endmodule
